// ----- rtl/core/pbd_pkg.sv -----
// Shared types and constants for the point-to-box distance metrics block.
// No dependencies; every other file imports this package.
package pbd_pkg;

   localparam int DIMS     = 3;   // active dimensions, 1 to 3
   localparam int MAX_DIMS = 3;   // dimensions present in the request
   localparam int COORD_W  = 16;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int SQ_W     = 2 * COORD_W;
   localparam int SUM_W    = SQ_W + 2;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic        [SQ_W-1:0]    sq_type;
   typedef logic        [SUM_W-1:0]   sum_type;

   typedef struct packed {
      coord_type point_0;
      coord_type point_1;
      coord_type point_2;
      coord_type box_low_0;
      coord_type box_high_0;
      coord_type box_low_1;
      coord_type box_high_1;
      coord_type box_low_2;
      coord_type box_high_2;
   } req_type;

   typedef struct packed {
      sum_type near_dist_sq;
      sum_type far_dist_sq;
      sum_type min_max_dist_sq;
   } rsp_type;

   // Per-dimension differences whose squares feed the sums.
   typedef struct packed {
      diff_type near_d;   // to nearest face, zero inside
      diff_type far_d;    // to farthest corner
      diff_type sfar_d;   // to edge on the far side of the midpoint
      diff_type rm_d;     // to edge on the near side of the midpoint
   } dim_diff_type;

endpackage

// ----- rtl/core/pbd_req_if.sv -----
// Request channel: valid/ready handshake carrying one point and one box.
// Depends on pbd_pkg.
interface pbd_req_if;
   import pbd_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pbd_rsp_if.sv -----
// Response channel: valid/ready handshake carrying the three squared metrics.
// Depends on pbd_pkg.
interface pbd_rsp_if;
   import pbd_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/pbd_dim_sel.sv -----
// Edge selection for one dimension: compares the point against the bounds and
// the midpoint and picks the differences to be squared. Depends on pbd_pkg.
module pbd_dim_sel (
   input  pbd_pkg::coord_type    p_in,
   input  pbd_pkg::coord_type    lo_in,
   input  pbd_pkg::coord_type    hi_in,
   output pbd_pkg::dim_diff_type diff_out
);
   import pbd_pkg::*;

   diff_type dl;       // p - lo
   diff_type dh;       // hi - p
   diff_type twice_p;
   diff_type ends;
   logic     lt;
   logic     gt;
   logic     ge;
   logic     le;

   assign dl      = DIFF_W'(p_in) - DIFF_W'(lo_in);
   assign dh      = DIFF_W'(hi_in) - DIFF_W'(p_in);
   assign twice_p = $signed({p_in, 1'b0});
   assign ends    = DIFF_W'(lo_in) + DIFF_W'(hi_in);
   assign lt      = p_in < lo_in;
   assign gt      = p_in > hi_in;
   assign ge      = twice_p >= ends;
   assign le      = twice_p <= ends;

   // Only squares are used, so |p - hi| is taken as hi - p.
   always_comb begin
      priority if (lt) begin
         diff_out.near_d = dl;
      end else if (gt) begin
         diff_out.near_d = dh;
      end else begin
         diff_out.near_d = '0;
      end
      // far corner: below lo wins over above hi for unordered bounds;
      // upper bound on a tie inside the box
      diff_out.far_d  = (!lt && (gt || (dl > dh))) ? dl : dh;
      diff_out.sfar_d = ge ? dl : dh;
      diff_out.rm_d   = le ? dl : dh;
   end

endmodule

// ----- rtl/core/point_box_distance_metrics.sv -----
// Point-to-box distance metrics: MINDIST, MAXDIST and MINMAXDIST, all squared.
// Depends on pbd_pkg, pbd_req_if, pbd_rsp_if and pbd_dim_sel.
//
// Usage:
//   req_chan (sink) takes one query point and one axis-aligned box per request;
//   a request is taken at a rising edge with valid and ready both high.
//   rsp_chan (source) returns near_dist_sq, far_dist_sq and min_max_dist_sq,
//   one response per request, in request order.
// Pipeline: five register stages (edge select, square, sum, candidate,
//   minimum/output register); the response is driven from the last one.
// Throughput: one request per cycle while rsp_chan.ready is high. Each stage
//   holds its own valid bit and loads whenever it is empty or its successor
//   moves, so empty slots close up and a full pipe takes a new request every
//   cycle while responses are being taken.
// Stall: while rsp_chan.ready is low the output register holds its response;
//   the four stages behind it keep filling, and req_chan.ready drops only
//   once all five stages hold a request. Nothing is dropped or repeated.
// Reset: synchronous, active high; clears all valid bits, so the pipe is
//   empty and ready the cycle after reset is released. No clearing pass.
// Bounds are not checked; unordered bounds give the same comparisons as given.
module point_box_distance_metrics (
   input logic       clock,
   input logic       reset,
   pbd_req_if.sink   req_chan,
   pbd_rsp_if.source rsp_chan
);
   import pbd_pkg::*;

   function automatic sq_type square(input diff_type d);
      logic signed [2*DIFF_W-1:0] prod;
      prod = d * d;
      return prod[SQ_W-1:0];
   endfunction

   coord_type    pt [MAX_DIMS];
   coord_type    lo [MAX_DIMS];
   coord_type    hi [MAX_DIMS];
   dim_diff_type sel [DIMS];

   assign pt[0] = req_chan.data.point_0;
   assign pt[1] = req_chan.data.point_1;
   assign pt[2] = req_chan.data.point_2;
   assign lo[0] = req_chan.data.box_low_0;
   assign lo[1] = req_chan.data.box_low_1;
   assign lo[2] = req_chan.data.box_low_2;
   assign hi[0] = req_chan.data.box_high_0;
   assign hi[1] = req_chan.data.box_high_1;
   assign hi[2] = req_chan.data.box_high_2;

   for (genvar g = 0; g < DIMS; g++) begin : g_dim
      pbd_dim_sel u_sel (
         .p_in    (pt[g]),
         .lo_in   (lo[g]),
         .hi_in   (hi[g]),
         .diff_out(sel[g])
      );
   end

   // ---------------- valid / ready chain ----------------
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic v1_in, v2_in, v3_in, v4_in, v5_in;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   assign rdy5 = !v5_ff || rsp_chan.ready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign req_chan.ready = rdy1;

   assign v1_in = rdy1 ? req_chan.valid : v1_ff;
   assign v2_in = rdy2 ? v1_ff : v2_ff;
   assign v3_in = rdy3 ? v2_ff : v3_ff;
   assign v4_in = rdy4 ? v3_ff : v4_ff;
   assign v5_in = rdy5 ? v4_ff : v5_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         v5_ff <= v5_in;
      end
   end

   // ---------------- stage 1: selected differences ----------------
   dim_diff_type d1_ff [DIMS];

   always_ff @(posedge clock) begin
      if (rdy1 && req_chan.valid) begin
         for (int i = 0; i < DIMS; i++) begin
            d1_ff[i] <= sel[i];
         end
      end
   end

   // ---------------- stage 2: squares ----------------
   sq_type near2_ff [DIMS];
   sq_type far2_ff  [DIMS];
   sq_type sfar2_ff [DIMS];
   sq_type rm2_ff   [DIMS];

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         for (int i = 0; i < DIMS; i++) begin
            near2_ff[i] <= square(d1_ff[i].near_d);
            far2_ff[i]  <= square(d1_ff[i].far_d);
            sfar2_ff[i] <= square(d1_ff[i].sfar_d);
            rm2_ff[i]   <= square(d1_ff[i].rm_d);
         end
      end
   end

   // ---------------- stage 3: sums ----------------
   sum_type near3_ff, far3_ff, s3_ff;
   sum_type near3_in, far3_in, s3_in;
   sq_type  sfar3_ff [DIMS];
   sq_type  rm3_ff   [DIMS];

   always_comb begin
      near3_in = '0;
      far3_in  = '0;
      s3_in    = '0;
      for (int i = 0; i < DIMS; i++) begin
         near3_in = near3_in + SUM_W'(near2_ff[i]);
         far3_in  = far3_in  + SUM_W'(far2_ff[i]);
         s3_in    = s3_in    + SUM_W'(sfar2_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         near3_ff <= near3_in;
         far3_ff  <= far3_in;
         s3_ff    <= s3_in;
         for (int i = 0; i < DIMS; i++) begin
            sfar3_ff[i] <= sfar2_ff[i];
            rm3_ff[i]   <= rm2_ff[i];
         end
      end
   end

   // ---------------- stage 4: MINMAXDIST candidates ----------------
   sum_type near4_ff, far4_ff;
   sum_type cand4_ff [DIMS];

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         near4_ff <= near3_ff;
         far4_ff  <= far3_ff;
         // s holds this dimension's far term, so the subtraction cannot wrap
         for (int i = 0; i < DIMS; i++) begin
            cand4_ff[i] <= s3_ff - SUM_W'(sfar3_ff[i]) + SUM_W'(rm3_ff[i]);
         end
      end
   end

   // ---------------- stage 5: minimum and output register ----------------
   sum_type best5_in;
   rsp_type out5_ff;

   always_comb begin
      best5_in = cand4_ff[0];
      for (int i = 1; i < DIMS; i++) begin
         if (cand4_ff[i] < best5_in) begin
            best5_in = cand4_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5 && v4_ff) begin
         out5_ff.near_dist_sq    <= near4_ff;
         out5_ff.far_dist_sq     <= far4_ff;
         out5_ff.min_max_dist_sq <= best5_in;
      end
   end

   assign rsp_chan.valid = v5_ff;
   assign rsp_chan.data  = out5_ff;

   // ---------------- assertions ----------------
   a_input_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (v1_ff && v2_ff && v3_ff && v4_ff && v5_ff))
      else $error("request port stalled with an empty stage");

   a_accept_enters_stage1: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> v1_ff)
      else $error("accepted request did not reach stage 1");

   a_stage2_from_stage1: assert property (@(posedge clock) disable iff (reset)
      $rose(v2_ff) |-> $past(v1_ff))
      else $error("stage 2 became valid without stage 1 data");

   a_out_from_stage4: assert property (@(posedge clock) disable iff (reset)
      $rose(v5_ff) |-> $past(v4_ff))
      else $error("response appeared without stage 4 data");

   a_stage3_held_on_stall: assert property (@(posedge clock) disable iff (reset)
      v3_ff && !rdy4 |=> v3_ff)
      else $error("stage 3 request lost during stall");

endmodule
